/* hdl/ssg_pkg.sv */
package ssg_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 24;
  localparam int PERIOD_W    = 17;
  localparam int STEPS_W     = 5;
  localparam int MASK_W      = 16;
  localparam int STEP_OUT_W  = 4;
  // Internal repeat index, wide enough for any step count up to 32
  localparam int IDX_W       = 5;

  // Config port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  // Largest value the period register can hold
  localparam int PERIOD_MAX  = (1 << PERIOD_W) - 1;

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEPS   = PERIOD_W;
  localparam int DIV_CNT_W   = 5;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd4800;
  localparam logic [STEPS_W-1:0]  STEPS_RESET  = 5'd4;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 16'hFFFF;
  localparam logic                MONO_RESET   = 1'b0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_STEPS     = 2'd1,
    REG_GATE_MASK = 2'd2,
    REG_MONO      = 2'd3
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t in_left;
    sample_t in_right;
  } sample_item_t;

  typedef struct packed {
    sample_t                 out_left;
    sample_t                 out_right;
    logic [STEP_OUT_W-1:0]   step_index;
    logic                    gate_open;
  } result_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;    // capture item, start divide
    logic div_step;  // one divider iteration
    logic mem_go;    // grain write or read, latch index
    logic out_load;  // load result, advance position
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

/* hdl/ssg_ram.sv */
module ssg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hdl/ssg_ctrl.sv */
module ssg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  ssg_pkg::dp_status_t status,
  output ssg_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MEM,
    S_LOAD
  } state_t;

  state_t state;
  logic   out_free;

  // Result register can take a new item
  assign out_free = !result_valid || !result_stall;

  assign sample_stall = (state != S_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && sample_valid;
    cmd.div_step = (state == S_DIV) && !status.div_done;
    cmd.mem_go   = (state == S_MEM);
    cmd.out_load = (state == S_LOAD) && out_free;
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (status.div_done) begin
            state <= S_MEM;
          end
        end
        S_MEM: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
      // Set on load, cleared once the item is taken
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // A loaded result is presented next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> result_valid)
    else $error("result not presented after load");

  // A waiting result is never overwritten
  a_load_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && result_valid && result_stall |=> (state == S_LOAD))
    else $error("result overwritten while stalled");

endmodule

/* hdl/ssg_datapath.sv */
module ssg_datapath #(
  parameter int GRAIN_DEPTH = 65536,
  parameter int MAX_STEPS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ssg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ssg_pkg::sample_item_t              sample,
  input  ssg_pkg::ctrl_cmd_t                 cmd,
  output ssg_pkg::dp_status_t                status,
  output ssg_pkg::result_item_t              result
);

  localparam int ADDR_W       = $clog2(GRAIN_DEPTH);
  localparam int PW           = ssg_pkg::PERIOD_W;
  localparam int PERIOD_LIMIT = (GRAIN_DEPTH < ssg_pkg::PERIOD_MAX) ?
                                GRAIN_DEPTH : ssg_pkg::PERIOD_MAX;
  localparam int STEPS_LIMIT  = (MAX_STEPS < 31) ? MAX_STEPS : 31;
  localparam logic [PW-1:0] PERIOD_CAP = PW'(PERIOD_LIMIT);
  localparam logic [PW-1:0] CHUNK_CAP  = PW'(PERIOD_LIMIT / 2);
  localparam logic [PW-1:0] IDX_CAP    = PW'(MAX_STEPS - 1);
  localparam logic [ssg_pkg::STEPS_W-1:0] STEPS_CAP =
    ssg_pkg::STEPS_W'(STEPS_LIMIT);

  // Config registers
  logic [PW-1:0]                   period_samples;
  logic [ssg_pkg::STEPS_W-1:0]     step_count;
  logic [ssg_pkg::MASK_W-1:0]      gate_mask;
  logic                            mono_mode;

  // Cycle state
  logic [PW-1:0] position;
  logic [PW-1:0] chunk_length;

  // Captured item
  ssg_pkg::sample_t live_left;
  ssg_pkg::sample_t live_right;
  logic             at_start;

  // Serial divider
  logic [PW-1:0]                 div_quo;
  logic [PW-1:0]                 div_rem;
  logic [PW-1:0]                 div_den;
  logic [ssg_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [PW:0]                   div_trial;
  logic [PW:0]                   div_diff;
  logic                          div_fits;

  // Memory stage
  logic [ssg_pkg::IDX_W-1:0] step_idx;
  logic                      live_path;
  logic                      mem_live;
  logic [ADDR_W-1:0]         ram_addr;
  logic                      ram_we;
  logic                      ram_re;
  logic [ssg_pkg::SAMPLE_BITS-1:0] grain_rd_left;
  logic [ssg_pkg::SAMPLE_BITS-1:0] grain_rd_right;

  // Effective values and helpers
  logic [PW-1:0]               period_eff;
  logic [ssg_pkg::STEPS_W-1:0] steps_eff;
  logic [PW-1:0]               chunk_eff;
  logic [PW:0]                 pos_inc;
  logic [ssg_pkg::IDX_W-1:0]   quo_capped;
  logic                        gate_hit;
  ssg_pkg::sample_t            sel_left;
  ssg_pkg::sample_t            sel_right;

  // Clamp period and step count
  always_comb begin
    if (period_samples < PW'(2)) begin
      period_eff = PW'(2);
    end else if (period_samples > PERIOD_CAP) begin
      period_eff = PERIOD_CAP;
    end else begin
      period_eff = period_samples;
    end
    if (step_count < ssg_pkg::STEPS_W'(2)) begin
      steps_eff = ssg_pkg::STEPS_W'(2);
    end else if (step_count > STEPS_CAP) begin
      steps_eff = STEPS_CAP;
    end else begin
      steps_eff = step_count;
    end
  end

  assign chunk_eff = (chunk_length == '0) ? PW'(1) : chunk_length;
  assign pos_inc   = {1'b0, position} + (PW+1)'(1);

  // Restoring divide, one bit per step
  assign div_trial = {div_rem, div_quo[PW-1]};
  assign div_fits  = (div_trial >= {1'b0, div_den});
  assign div_diff  = div_trial - {1'b0, div_den};

  assign status.div_done = (div_cnt == '0);

  // Repeat index, capped at the last step
  assign quo_capped = (div_quo > IDX_CAP) ? ssg_pkg::IDX_W'(IDX_CAP)
                                          : div_quo[ssg_pkg::IDX_W-1:0];

  // First chunk of a cycle is recorded, the rest replays
  assign mem_live = at_start || (position < chunk_length);
  assign ram_addr = mem_live ? ADDR_W'(position) : ADDR_W'(div_rem);
  assign ram_we   = cmd.mem_go && mem_live;
  assign ram_re   = cmd.mem_go && !mem_live;

  ssg_ram #(
    .WIDTH (ssg_pkg::SAMPLE_BITS),
    .DEPTH (GRAIN_DEPTH)
  ) u_grain_left (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (live_left),
    .rdata (grain_rd_left)
  );

  ssg_ram #(
    .WIDTH (ssg_pkg::SAMPLE_BITS),
    .DEPTH (GRAIN_DEPTH)
  ) u_grain_right (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (live_right),
    .rdata (grain_rd_right)
  );

  // Gate and output select
  assign gate_hit  = !step_idx[ssg_pkg::IDX_W-1] &&
                     gate_mask[step_idx[ssg_pkg::STEP_OUT_W-1:0]];
  assign sel_left  = live_path ? live_left  : $signed(grain_rd_left);
  assign sel_right = live_path ? live_right : $signed(grain_rd_right);

  // Control state: config, position, chunk, divider count
  always_ff @(posedge clk) begin
    if (rst) begin
      period_samples <= ssg_pkg::PERIOD_RESET;
      step_count     <= ssg_pkg::STEPS_RESET;
      gate_mask      <= ssg_pkg::MASK_RESET;
      mono_mode      <= ssg_pkg::MONO_RESET;
      position       <= '0;
      chunk_length   <= '0;
      div_cnt        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (ssg_pkg::cfg_reg_t'(cfg_index))
          ssg_pkg::REG_PERIOD:    period_samples <= cfg_data[PW-1:0];
          ssg_pkg::REG_STEPS:     step_count     <= cfg_data[ssg_pkg::STEPS_W-1:0];
          ssg_pkg::REG_GATE_MASK: gate_mask      <= cfg_data[ssg_pkg::MASK_W-1:0];
          ssg_pkg::REG_MONO:      mono_mode      <= cfg_data[0];
        endcase
      end
      if (cmd.accept) begin
        div_cnt <= ssg_pkg::DIV_CNT_W'(ssg_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - ssg_pkg::DIV_CNT_W'(1);
      end
      // New chunk length at the start of a cycle, at least one
      if (cmd.mem_go && at_start) begin
        chunk_length <= (div_quo == '0) ? PW'(1) : div_quo;
      end
      if (cmd.out_load) begin
        position <= (pos_inc >= {1'b0, period_eff}) ? '0 : pos_inc[PW-1:0];
      end
    end
  end

  // Payload: captured item, divider data, result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      live_left  <= sample.in_left;
      live_right <= mono_mode ? sample.in_left : sample.in_right;
      at_start   <= (position == '0);
      div_rem    <= '0;
      if (position == '0) begin
        div_quo <= period_eff;
        div_den <= PW'(steps_eff);
      end else begin
        div_quo <= position;
        div_den <= chunk_eff;
      end
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[PW-2:0], div_fits};
      div_rem <= div_fits ? div_diff[PW-1:0] : div_trial[PW-1:0];
    end
    if (cmd.mem_go) begin
      step_idx  <= at_start ? '0 : quo_capped;
      live_path <= mem_live;
    end
    if (cmd.out_load) begin
      result.out_left   <= gate_hit ? sel_left  : '0;
      result.out_right  <= gate_hit ? sel_right : '0;
      result.step_index <= step_idx[ssg_pkg::STEP_OUT_W-1:0];
      result.gate_open  <= gate_hit;
    end
  end

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    div_cnt <= ssg_pkg::DIV_CNT_W'(ssg_pkg::DIV_STEPS))
    else $error("divider count out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position < PERIOD_CAP)
    else $error("cycle position beyond largest period");

  a_chunk_range: assert property (@(posedge clk) disable iff (rst)
    chunk_length <= CHUNK_CAP)
    else $error("chunk length exceeds grain memory half");

endmodule

/* hdl/stereo_stutter_gate_unit.sv */
// Each accepted item passes through the capture, the serial divider steps,
// a grain memory access and a result load before its result is valid; a new
// item is taken only after the load, which waits while the output is stalled.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): registers to defaults, cycle position and chunk to
// zero, no result pending; grain memories keep their contents.
module stereo_stutter_gate_unit #(
  parameter int GRAIN_DEPTH = 65536,
  parameter int MAX_STEPS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ssg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  ssg_pkg::sample_item_t           sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output ssg_pkg::result_item_t           result
);

  ssg_pkg::ctrl_cmd_t  cmd;
  ssg_pkg::dp_status_t status;

  ssg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  ssg_datapath #(
    .GRAIN_DEPTH (GRAIN_DEPTH),
    .MAX_STEPS   (MAX_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int GRAIN_DEPTH = 65536;
  localparam int MAX_STEPS   = 16;
  localparam int IDLE_PCT    = 11;
  localparam int RAND_ITEMS  = 1450;
  localparam int CYCLE_LIMIT = 400000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [ssg_pkg::CFG_INDEX_W-1:0] cfg_index = ssg_pkg::REG_PERIOD;
  logic [ssg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            sample_valid = 1'b0;
  logic                            sample_stall;
  ssg_pkg::sample_item_t           sample = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  ssg_pkg::result_item_t           result;

  // Shadow registers and state of the stutter predictor
  logic [ssg_pkg::PERIOD_W-1:0] sh_period = ssg_pkg::PERIOD_RESET;
  logic [ssg_pkg::STEPS_W-1:0]  sh_steps  = ssg_pkg::STEPS_RESET;
  logic [ssg_pkg::MASK_W-1:0]   sh_mask   = ssg_pkg::MASK_RESET;
  logic                         sh_mono   = ssg_pkg::MONO_RESET;
  int unsigned                  cyc_pos   = 0;
  int unsigned                  chunk_len = 0;
  ssg_pkg::sample_t             grain_l [GRAIN_DEPTH];
  ssg_pkg::sample_t             grain_r [GRAIN_DEPTH];

  ssg_pkg::sample_item_t sample_q[$];
  ssg_pkg::result_item_t predicted_q[$];
  ssg_pkg::result_item_t want;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_muted    = 0;
  int n_replayed = 0;
  int n_settings = 0;
  int err_count  = 0;
  int idle_pct   = IDLE_PCT;
  int cycle_cnt  = 0;

  stereo_stutter_gate_unit #(
    .GRAIN_DEPTH(GRAIN_DEPTH),
    .MAX_STEPS  (MAX_STEPS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #1 clk = ~clk;

  // Expected output for one stereo sample; advances the cycle position
  function automatic ssg_pkg::result_item_t stutter_predict(ssg_pkg::sample_item_t s);
    int unsigned           per;
    int unsigned           stp;
    int unsigned           chunk;
    int unsigned           idx;
    int unsigned           g;
    ssg_pkg::sample_t      l;
    ssg_pkg::sample_t      r;
    logic                  gate_on;
    ssg_pkg::result_item_t o;
    per = (sh_period < 2) ? 2 : ((sh_period > GRAIN_DEPTH) ? GRAIN_DEPTH : sh_period);
    stp = (sh_steps < 2) ? 2 : ((sh_steps > MAX_STEPS) ? MAX_STEPS : sh_steps);
    l = s.in_left;
    r = sh_mono ? s.in_left : s.in_right;
    // chunk length is latched at the start of each cycle only
    if (cyc_pos == 0) begin
      chunk_len = per / stp;
      if (chunk_len < 1) chunk_len = 1;
    end
    chunk = (chunk_len == 0) ? 1 : chunk_len;
    idx = cyc_pos / chunk;
    if (idx > MAX_STEPS - 1) idx = MAX_STEPS - 1;
    gate_on = (idx < ssg_pkg::MASK_W) && sh_mask[idx];
    if (cyc_pos < chunk_len) begin
      // first chunk: record the grain and pass through
      grain_l[cyc_pos] = l;
      grain_r[cyc_pos] = r;
      o.out_left  = l;
      o.out_right = r;
    end else begin
      g = cyc_pos % chunk;
      o.out_left  = grain_l[g];
      o.out_right = grain_r[g];
      n_replayed++;
    end
    if (!gate_on) begin
      o.out_left  = '0;
      o.out_right = '0;
    end
    o.step_index = idx[ssg_pkg::STEP_OUT_W-1:0];
    o.gate_open  = gate_on;
    cyc_pos++;
    if (cyc_pos >= per) cyc_pos = 0;
    return o;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 40) $display("tb: mismatch: %s", msg);
  endtask

  // Sender: one item per handshake, random gaps
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        predicted_q.push_back(stutter_predict(sample));
        n_accepted++;
      end
      if (!sample_valid || !sample_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          sample       <= sample_q.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_q.size() == 0) begin
          flag_error($sformatf("unexpected result %h", result));
        end else begin
          want = predicted_q.pop_front();
          n_checked++;
          if (!want.gate_open) n_muted++;
          if (result.out_left !== want.out_left)
            flag_error($sformatf("item %0d out_left %h, want %h",
                                 n_checked, result.out_left, want.out_left));
          if (result.out_right !== want.out_right)
            flag_error($sformatf("item %0d out_right %h, want %h",
                                 n_checked, result.out_right, want.out_right));
          if (result.step_index !== want.step_index)
            flag_error($sformatf("item %0d step_index %0d, want %0d",
                                 n_checked, result.step_index, want.step_index));
          if (result.gate_open !== want.gate_open)
            flag_error($sformatf("item %0d gate_open %b, want %b",
                                 n_checked, result.gate_open, want.gate_open));
        end
      end
      result_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, predicted_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_reg(ssg_pkg::cfg_reg_t r, int unsigned v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v[ssg_pkg::CFG_DATA_W-1:0];
    case (r)
      ssg_pkg::REG_PERIOD:    sh_period = v[ssg_pkg::PERIOD_W-1:0];
      ssg_pkg::REG_STEPS:     sh_steps  = v[ssg_pkg::STEPS_W-1:0];
      ssg_pkg::REG_GATE_MASK: sh_mask   = v[ssg_pkg::MASK_W-1:0];
      ssg_pkg::REG_MONO:      sh_mono   = v[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(int unsigned per, int unsigned stp, int unsigned mask,
                               int unsigned mono);
    write_reg(ssg_pkg::REG_PERIOD, per);
    write_reg(ssg_pkg::REG_STEPS, stp);
    write_reg(ssg_pkg::REG_GATE_MASK, mask);
    write_reg(ssg_pkg::REG_MONO, mono);
    n_settings++;
  endtask

  task automatic queue_item(ssg_pkg::sample_item_t s);
    sample_q.push_back(s);
    n_queued++;
  endtask

  // Hold the sender until every item has been answered
  task automatic drain();
    while (n_accepted != n_queued || predicted_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic ssg_pkg::sample_t pick_sample();
    logic [ssg_pkg::SAMPLE_BITS-1:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: v = 24'h7FFFFF;
          1: v = 24'h800000;
          2: v = 24'h000000;
          default: v = 24'hFFFFFF;
        endcase
      end
      default: v = ssg_pkg::SAMPLE_BITS'($urandom());
    endcase
    return v;
  endfunction

  int unsigned per_v;
  int unsigned stp_v;
  int unsigned mask_v;
  int n_rand;
  int cnt;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: sample extremes on both channels
    queue_item({24'h7FFFFF, 24'h800000});
    queue_item({24'h800000, 24'h7FFFFF});
    queue_item({24'h000000, 24'hFFFFFF});
    queue_item({24'hFFFFFF, 24'h000000});
    drain();

    // Period below range, step count above range, position past the new period
    apply_setting(0, 31, 16'hFFFF, 0);
    repeat (3) queue_item({pick_sample(), pick_sample()});
    drain();

    // One-sample chunks, step index pinned at the top, sparse mask, mono
    apply_setting(17, 16, 16'h8A53, 1);
    repeat (18) queue_item({pick_sample(), pick_sample()});
    drain();

    // Random settings, each followed by a burst of samples
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      case ($urandom_range(9))
        0: per_v = $urandom_range(0, 3);
        1: begin
          case ($urandom_range(3))
            0: per_v = 65535;
            1: per_v = 65536;
            2: per_v = 65537;
            default: per_v = 131071;
          endcase
        end
        2: per_v = $urandom_range(41, 400);
        default: per_v = $urandom_range(2, 40);
      endcase
      case ($urandom_range(5))
        0: stp_v = $urandom_range(0, 1);
        1: stp_v = $urandom_range(16, 31);
        2: stp_v = 2;
        default: stp_v = $urandom_range(2, 16);
      endcase
      case ($urandom_range(4))
        0: mask_v = 16'h0000;
        1: mask_v = 16'hFFFF;
        default: mask_v = $urandom_range(0, 65535);
      endcase
      apply_setting(per_v, stp_v, mask_v, $urandom_range(1));
      // one long burst with neither side idling
      idle_pct = (n_settings == 6) ? 0 : IDLE_PCT;
      cnt = (idle_pct == 0) ? 150 : $urandom_range(20, 110);
      if (cnt > RAND_ITEMS - n_rand) cnt = RAND_ITEMS - n_rand;
      repeat (cnt) queue_item({pick_sample(), pick_sample()});
      n_rand += cnt;
      drain();
    end
    idle_pct = IDLE_PCT;
    repeat (30) @(posedge clk);

    $display("tb: %0d samples checked under %0d register settings", n_checked, n_settings);
    $display("tb: %0d replayed from the grain, %0d muted by the gate mask",
             n_replayed, n_muted);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
